// ===== rtl/core/dcgg_pkg.sv =====
package dcgg_pkg;

    localparam int COORD_W   = 24;
    localparam int VAL_W     = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int VSUM_W    = VAL_W + 1;
    localparam int PROD_W    = DIFF_W + VSUM_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int DPROD_W   = 2 * DIFF_W;
    localparam int DET_W     = DPROD_W + 1;
    localparam int DMAG_W    = DET_W - 1;
    localparam int GRAD_W    = 48;
    localparam int FRAC_SH   = 16;
    localparam int NUM_W     = SUM_W + FRAC_SH;
    localparam int DIV_STEPS = GRAD_W;
    localparam int HI_W      = NUM_W - DIV_STEPS;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic signed [COORD_W-1:0] x3;
        logic signed [COORD_W-1:0] y3;
        logic signed [VAL_W-1:0]   val0;
        logic signed [VAL_W-1:0]   val1;
        logic signed [VAL_W-1:0]   val2;
        logic signed [VAL_W-1:0]   val3;
    } in_word_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic signed [VAL_W-1:0]  face_average;
        logic                     degenerate;
        logic                     saturated;
    } out_word_t;

    // Fields that ride along the divider untouched
    typedef struct packed {
        logic                    neg_x;
        logic                    neg_y;
        logic                    degenerate;
        logic signed [VAL_W-1:0] face_average;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0]  num_x;
        logic [NUM_W-1:0]  num_y;
        logic [DMAG_W-1:0] dmag;
        side_t             side;
    } div_in_t;

    typedef struct packed {
        logic [DIV_STEPS-1:0] quo_x;
        logic [DIV_STEPS-1:0] quo_y;
        logic                 ovf_x;
        logic                 ovf_y;
        side_t                side;
    } div_out_t;

    typedef struct packed {
        logic [DMAG_W-1:0]    rem;
        logic [DIV_STEPS-1:0] nq;
    } step_t;

    // One restoring step: numerator bits shift out the top of nq, quotient bits in the bottom
    function automatic step_t div_step(input logic [DMAG_W-1:0] rem,
                                       input logic [DIV_STEPS-1:0] nq,
                                       input logic [DMAG_W-1:0] dmag);
        logic [DMAG_W:0] trial;
        logic [DMAG_W:0] diff;
        step_t           res;
        trial = {rem, nq[DIV_STEPS-1]};
        diff  = trial - {1'b0, dmag};
        if (trial >= {1'b0, dmag}) begin
            res.rem = diff[DMAG_W-1:0];
            res.nq  = {nq[DIV_STEPS-2:0], 1'b1};
        end else begin
            res.rem = trial[DMAG_W-1:0];
            res.nq  = {nq[DIV_STEPS-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/dcgg_div.sv =====
module dcgg_div
    import dcgg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  div_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output div_out_t out_data
);

    localparam int Depth = DIV_STEPS + 1;

    logic [Depth-1:0]     v_reg;
    logic [Depth:0]       en;
    logic [DMAG_W-1:0]    remx_reg [Depth];
    logic [DMAG_W-1:0]    remy_reg [Depth];
    logic [DIV_STEPS-1:0] nqx_reg  [Depth];
    logic [DIV_STEPS-1:0] nqy_reg  [Depth];
    logic [DMAG_W-1:0]    dmag_reg [Depth];
    logic                 ovfx_reg [Depth];
    logic                 ovfy_reg [Depth];
    side_t                side_reg [Depth];

    logic [HI_W-1:0]      hix;
    logic [HI_W-1:0]      hiy;

    assign en[Depth] = !out_stall;
    assign in_stall  = !en[0];
    assign hix       = in_data.num_x[NUM_W-1:DIV_STEPS];
    assign hiy       = in_data.num_y[NUM_W-1:DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < Depth; k++) begin : g_en
            assign en[k] = !v_reg[k] || en[k+1];
        end
    endgenerate

    // Stage 0: load the high numerator part as the first remainder, flag quotient overflow
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg[0] <= 1'b0;
        end else if (en[0]) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en[0] && in_valid) begin
            remx_reg[0] <= DMAG_W'(hix);
            remy_reg[0] <= DMAG_W'(hiy);
            nqx_reg[0]  <= in_data.num_x[DIV_STEPS-1:0];
            nqy_reg[0]  <= in_data.num_y[DIV_STEPS-1:0];
            dmag_reg[0] <= in_data.dmag;
            ovfx_reg[0] <= DMAG_W'(hix) >= in_data.dmag;
            ovfy_reg[0] <= DMAG_W'(hiy) >= in_data.dmag;
            side_reg[0] <= in_data.side;
        end
    end

    generate
        for (k = 1; k < Depth; k++) begin : g_step
            step_t sx;
            step_t sy;
            assign sx = div_step(remx_reg[k-1], nqx_reg[k-1], dmag_reg[k-1]);
            assign sy = div_step(remy_reg[k-1], nqy_reg[k-1], dmag_reg[k-1]);

            always_ff @(posedge clk or negedge rst_n) begin
                if (!rst_n) begin
                    v_reg[k] <= 1'b0;
                end else if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end

            always_ff @(posedge clk) begin
                if (en[k] && v_reg[k-1]) begin
                    remx_reg[k] <= sx.rem;
                    remy_reg[k] <= sy.rem;
                    nqx_reg[k]  <= sx.nq;
                    nqy_reg[k]  <= sy.nq;
                    dmag_reg[k] <= dmag_reg[k-1];
                    ovfx_reg[k] <= ovfx_reg[k-1];
                    ovfy_reg[k] <= ovfy_reg[k-1];
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    endgenerate

    assign out_valid      = v_reg[Depth-1];
    assign out_data.quo_x = nqx_reg[Depth-1];
    assign out_data.quo_y = nqy_reg[Depth-1];
    assign out_data.ovf_x = ovfx_reg[Depth-1];
    assign out_data.ovf_y = ovfy_reg[Depth-1];
    assign out_data.side  = side_reg[Depth-1];

endmodule

// ===== rtl/core/diamond_cell_green_gauss_gradient.sv =====
// Diamond-cell Green-Gauss gradient, one 2-D face per word.
// Input channel in_valid/in_stall/in_data carries the four corners (face node 0,
// left centre, face node 1, right centre, Q8.16) and their values (Q16.16).
// Output channel out_valid/out_stall/out_data returns grad_x, grad_y (Q32.16,
// rounded to nearest, ties away from zero, saturated), the floor mean of the two
// face node values, a degenerate flag (zero determinant, gradients forced to 0)
// and a saturated flag.
// The pipeline has 4 front stages (edge differences, multiplies, sums,
// magnitude and numerator), 49 divider stages (one load stage and one restoring
// quotient bit per stage, both gradients in parallel lanes) and an output register.
// Throughput is one word per cycle while out_stall is low; the long division pipeline sets the latency.
// Every stage holds its own valid bit and advances when empty or when the stage
// after it advances, so bubbles close up and a stalled receiver backs words up
// stage by stage; in_stall rises only once every stage is full.
// Reset clears all valid bits; no word is in flight afterwards.
module diamond_cell_green_gauss_gradient
    import dcgg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    localparam int FrontDepth = 4;

    logic [FrontDepth-1:0] v_reg;
    logic [FrontDepth-1:0] v_next;
    logic [FrontDepth:0]   en;
    logic                  div_stall;
    logic                  div_valid;
    div_out_t              div_res;
    div_in_t               div_word;
    logic                  out_en;

    // Stage 1 registers
    logic signed [DIFF_W-1:0] nx_reg [4];
    logic signed [DIFF_W-1:0] ny_reg [4];
    logic signed [VSUM_W-1:0] vs_reg [4];
    logic signed [DIFF_W-1:0] da_reg, db_reg, dc_reg, dd_reg;
    logic signed [VAL_W-1:0]  avg1_reg;
    // Stage 2 registers
    logic signed [PROD_W-1:0]  px_reg [4];
    logic signed [PROD_W-1:0]  py_reg [4];
    logic signed [DPROD_W-1:0] pd0_reg, pd1_reg;
    logic signed [VAL_W-1:0]   avg2_reg;
    // Stage 3 registers
    logic signed [SUM_W-1:0] sx_reg, sy_reg;
    logic signed [DET_W-1:0] det_reg;
    logic signed [VAL_W-1:0] avg3_reg;
    // Stage 4 register
    div_in_t                 div_word_reg;

    out_word_t               out_reg;
    out_word_t               out_next;
    logic                    outv_reg;

    logic signed [COORD_W-1:0] xs [4];
    logic signed [COORD_W-1:0] ys [4];
    logic signed [VAL_W-1:0]   vv [4];
    logic signed [DIFF_W-1:0]  nx_next [4];
    logic signed [DIFF_W-1:0]  ny_next [4];
    logic signed [VSUM_W-1:0]  vs_next [4];
    logic signed [VSUM_W-1:0]  fsum;

    assign xs = '{in_data.x0, in_data.x1, in_data.x2, in_data.x3};
    assign ys = '{in_data.y0, in_data.y1, in_data.y2, in_data.y3};
    assign vv = '{in_data.val0, in_data.val1, in_data.val2, in_data.val3};

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            nx_next[i] = DIFF_W'(ys[(i+1)%4]) - DIFF_W'(ys[i]);
            ny_next[i] = DIFF_W'(xs[i]) - DIFF_W'(xs[(i+1)%4]);
            vs_next[i] = VSUM_W'(vv[i]) + VSUM_W'(vv[(i+1)%4]);
        end
        fsum = VSUM_W'(in_data.val0) + VSUM_W'(in_data.val2);
    end

    assign en[FrontDepth] = !div_stall;
    assign in_stall       = !en[0];
    assign v_next         = {v_reg[FrontDepth-2:0], in_valid};

    genvar k;
    generate
        for (k = 0; k < FrontDepth; k++)
        begin : g_en
            assign en[k] = !v_reg[k] || en[k+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < FrontDepth; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // Stage 1: edge normals, value sums, determinant legs, face mean
    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            vs_reg   <= vs_next;
            da_reg   <= DIFF_W'(in_data.x2) - DIFF_W'(in_data.x0);
            db_reg   <= DIFF_W'(in_data.y3) - DIFF_W'(in_data.y1);
            dc_reg   <= DIFF_W'(in_data.x3) - DIFF_W'(in_data.x1);
            dd_reg   <= DIFF_W'(in_data.y2) - DIFF_W'(in_data.y0);
            avg1_reg <= fsum[VSUM_W-1:1];
        end
    end

    // Stage 2: multiplies
    always_ff @(posedge clk)
    begin
        if (en[1] && v_reg[0])
        begin
            for (int i = 0; i < 4; i++)
            begin
                px_reg[i] <= PROD_W'(nx_reg[i]) * PROD_W'(vs_reg[i]);
                py_reg[i] <= PROD_W'(ny_reg[i]) * PROD_W'(vs_reg[i]);
            end
            pd0_reg  <= DPROD_W'(da_reg) * DPROD_W'(db_reg);
            pd1_reg  <= DPROD_W'(dc_reg) * DPROD_W'(dd_reg);
            avg2_reg <= avg1_reg;
        end
    end

    // Stage 3: edge sums and determinant
    always_ff @(posedge clk)
    begin
        if (en[2] && v_reg[1])
        begin
            sx_reg   <= SUM_W'(px_reg[0]) + SUM_W'(px_reg[1])
                      + SUM_W'(px_reg[2]) + SUM_W'(px_reg[3]);
            sy_reg   <= SUM_W'(py_reg[0]) + SUM_W'(py_reg[1])
                      + SUM_W'(py_reg[2]) + SUM_W'(py_reg[3]);
            det_reg  <= DET_W'(pd0_reg) - DET_W'(pd1_reg);
            avg3_reg <= avg2_reg;
        end
    end

    // Stage 4: magnitudes, scaled numerators with half-divisor rounding bias
    logic [SUM_W-1:0] magx, magy;
    logic [DET_W-1:0] magd;

    always_comb
    begin
        magx = sx_reg[SUM_W-1] ? SUM_W'(-sx_reg) : SUM_W'(sx_reg);
        magy = sy_reg[SUM_W-1] ? SUM_W'(-sy_reg) : SUM_W'(sy_reg);
        magd = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
        div_word.dmag  = magd[DMAG_W-1:0];
        div_word.num_x = (NUM_W'(magx) << FRAC_SH) + NUM_W'(magd[DMAG_W-1:1]);
        div_word.num_y = (NUM_W'(magy) << FRAC_SH) + NUM_W'(magd[DMAG_W-1:1]);
        div_word.side.neg_x        = sx_reg[SUM_W-1] ^ det_reg[DET_W-1];
        div_word.side.neg_y        = sy_reg[SUM_W-1] ^ det_reg[DET_W-1];
        div_word.side.degenerate   = (det_reg == '0);
        div_word.side.face_average = avg3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3] && v_reg[2])
        begin
            div_word_reg <= div_word;
        end
    end

    dcgg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[FrontDepth-1]),
        .in_stall  (div_stall),
        .in_data   (div_word_reg),
        .out_valid (div_valid),
        .out_stall (!out_en),
        .out_data  (div_res)
    );

    // Output stage: sign, saturation, degenerate override
    localparam logic [GRAD_W-1:0] MaxPos = {1'b0, {(GRAD_W-1){1'b1}}};
    localparam logic [GRAD_W-1:0] MaxNeg = {1'b1, {(GRAD_W-1){1'b0}}};

    logic             satx, saty;
    logic [GRAD_W-1:0] gx, gy;

    always_comb
    begin
        if (div_res.side.neg_x)
        begin
            satx = div_res.ovf_x || (div_res.quo_x[GRAD_W-1] && |div_res.quo_x[GRAD_W-2:0]);
            gx   = satx ? MaxNeg : GRAD_W'(-div_res.quo_x);
        end
        else
        begin
            satx = div_res.ovf_x || div_res.quo_x[GRAD_W-1];
            gx   = satx ? MaxPos : div_res.quo_x;
        end
        if (div_res.side.neg_y)
        begin
            saty = div_res.ovf_y || (div_res.quo_y[GRAD_W-1] && |div_res.quo_y[GRAD_W-2:0]);
            gy   = saty ? MaxNeg : GRAD_W'(-div_res.quo_y);
        end
        else
        begin
            saty = div_res.ovf_y || div_res.quo_y[GRAD_W-1];
            gy   = saty ? MaxPos : div_res.quo_y;
        end
        out_next.face_average = div_res.side.face_average;
        out_next.degenerate   = div_res.side.degenerate;
        if (div_res.side.degenerate)
        begin
            out_next.grad_x    = '0;
            out_next.grad_y    = '0;
            out_next.saturated = 1'b0;
        end
        else
        begin
            out_next.grad_x    = gx;
            out_next.grad_y    = gy;
            out_next.saturated = satx || saty;
        end
    end

    assign out_en = !outv_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outv_reg <= 1'b0;
        end
        else if (out_en)
        begin
            outv_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && div_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = outv_reg;
    assign out_data  = out_reg;

endmodule
